/* src/sudt_pkg.sv */
// Package for the sorted unique date table.
// Holds sizes, the date word type, status codes and the port structs.
// No dependencies.
`timescale 1ns / 1ps

package sudt_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DATE_W  = YEAR_W + MONTH_W + DAY_W;
    localparam int STAT_W  = 3;

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [DATE_W-1:0] date_t;
    typedef logic [STAT_W-1:0] stat_t;

    localparam cnt_t CAP_CNT = cnt_t'(CAPACITY);

    localparam stat_t ST_INSERTED = 3'd0;
    localparam stat_t ST_DUP      = 3'd1;
    localparam stat_t ST_FULL     = 3'd2;
    localparam stat_t ST_LISTED   = 3'd3;
    localparam stat_t ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic  re;
        addr_t raddr;
        logic  we;
        addr_t waddr;
        date_t wdata;
    } mem_req_t;

    typedef struct packed {
        logic eq;
        logic gt;
    } cmp_res_t;

endpackage

/* src/sudt_cmp.sv */
// Date compare unit: orders a stored date word against the key.
// Depends on sudt_pkg.
`timescale 1ns / 1ps

module sudt_cmp
(
    input  sudt_pkg::date_t    entry,
    input  sudt_pkg::date_t    key,
    output sudt_pkg::cmp_res_t res
);

    // packed {year, month, day} orders as one unsigned word
    assign res.eq = (entry == key);
    assign res.gt = (entry > key);

endmodule

/* src/sudt_table.sv */
// Date storage: one write port and one registered read port.
// Depends on sudt_pkg.
`timescale 1ns / 1ps

module sudt_table
(
    input  logic               clk,
    input  sudt_pkg::mem_req_t req,
    output sudt_pkg::date_t    rd_data
);

    sudt_pkg::date_t mem [sudt_pkg::CAPACITY];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data <= mem[req.raddr];
        end
    end

endmodule

/* src/sorted_unique_date_table.sv */
// Sorted unique date table: insert with duplicate check, ordered listing.
// Insert runs a forward scan, a shift and a write; list reads the stored dates in order;
// one table read port serves both, one entry per cycle.
// Each result word is registered and appears in the cycle after it is produced, one word per cycle.
// busy is high from the accepted word until the last result; the receiver cannot stall.
// Reset (rst_n low, async) empties the table; stored dates are not cleared.
`timescale 1ns / 1ps

module sorted_unique_date_table
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            func,
    input  logic [sudt_pkg::YEAR_W-1:0]     year,
    input  logic [sudt_pkg::MONTH_W-1:0]    month,
    input  logic [sudt_pkg::DAY_W-1:0]      day,
    output logic                            valid,
    output logic [sudt_pkg::STAT_W-1:0]     status,
    output logic [sudt_pkg::YEAR_W-1:0]     out_year,
    output logic [sudt_pkg::MONTH_W-1:0]    out_month,
    output logic [sudt_pkg::DAY_W-1:0]      out_day,
    output logic                            last
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_LIST  = 2'd3;

    logic [1:0]          state_reg, state_next;
    sudt_pkg::cnt_t      cnt_reg, cnt_next;
    sudt_pkg::cnt_t      idx_reg, idx_next;
    sudt_pkg::cnt_t      pos_reg, pos_next;
    sudt_pkg::addr_t     wa_reg, wa_next;
    logic                pend_reg, pend_next;
    sudt_pkg::date_t     key_reg, key_next;

    logic                valid_reg, valid_next;
    logic                last_reg, last_next;
    sudt_pkg::stat_t     status_reg, status_next;
    sudt_pkg::date_t     odate_reg, odate_next;

    sudt_pkg::mem_req_t  req;
    sudt_pkg::date_t     rd_data;
    sudt_pkg::cmp_res_t  cmp;
    sudt_pkg::cnt_t      idx_dec;

    sudt_table u_table
    (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    sudt_cmp u_cmp
    (
        .entry (rd_data),
        .key   (key_reg),
        .res   (cmp)
    );

    assign idx_dec = idx_reg - sudt_pkg::cnt_t'(1);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        wa_next     = wa_reg;
        pend_next   = pend_reg;
        key_next    = key_reg;
        valid_next  = 1'b0;
        last_next   = last_reg;
        status_next = status_reg;
        odate_next  = odate_reg;
        req         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next  = {year, month, day};
                    idx_next  = '0;
                    pend_next = 1'b0;
                    state_next = func ? S_LIST : S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (pend_reg && cmp.eq)
                begin
                    valid_next  = 1'b1;
                    status_next = sudt_pkg::ST_DUP;
                    odate_next  = '0;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if ((pend_reg && cmp.gt) || (idx_reg == cnt_reg))
                begin
                    pos_next  = (pend_reg && cmp.gt) ? idx_dec : cnt_reg;
                    pend_next = 1'b0;
                    if (cnt_reg >= sudt_pkg::CAP_CNT)
                    begin
                        valid_next  = 1'b1;
                        status_next = sudt_pkg::ST_FULL;
                        odate_next  = '0;
                        last_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = cnt_reg;
                        state_next = S_SHIFT;
                    end
                end
                else
                begin
                    req.re    = 1'b1;
                    req.raddr = idx_reg[sudt_pkg::ADDR_W-1:0];
                    idx_next  = idx_reg + sudt_pkg::cnt_t'(1);
                    pend_next = 1'b1;
                end
            end

            S_SHIFT:
            begin
                // move each larger entry up by one, top first
                if (pend_reg)
                begin
                    req.we    = 1'b1;
                    req.waddr = wa_reg;
                    req.wdata = rd_data;
                end
                if (idx_reg > pos_reg)
                begin
                    req.re    = 1'b1;
                    req.raddr = idx_dec[sudt_pkg::ADDR_W-1:0];
                    wa_next   = idx_reg[sudt_pkg::ADDR_W-1:0];
                    idx_next  = idx_dec;
                    pend_next = 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    req.we      = 1'b1;
                    req.waddr   = pos_reg[sudt_pkg::ADDR_W-1:0];
                    req.wdata   = key_reg;
                    cnt_next    = cnt_reg + sudt_pkg::cnt_t'(1);
                    valid_next  = 1'b1;
                    status_next = sudt_pkg::ST_INSERTED;
                    odate_next  = '0;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_LIST:
            begin
                if (cnt_reg == '0)
                begin
                    valid_next  = 1'b1;
                    status_next = sudt_pkg::ST_EMPTY;
                    odate_next  = '0;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    if (pend_reg)
                    begin
                        valid_next  = 1'b1;
                        status_next = sudt_pkg::ST_LISTED;
                        odate_next  = rd_data;
                        last_next   = (idx_reg == cnt_reg);
                        if (idx_reg == cnt_reg)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    if (idx_reg < cnt_reg)
                    begin
                        req.re    = 1'b1;
                        req.raddr = idx_reg[sudt_pkg::ADDR_W-1:0];
                        idx_next  = idx_reg + sudt_pkg::cnt_t'(1);
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        wa_reg     <= wa_next;
        key_reg    <= key_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        odate_reg  <= odate_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign valid     = valid_reg;
    assign status    = status_reg;
    assign last      = last_reg;
    assign out_year  = odate_reg[sudt_pkg::DATE_W-1 -: sudt_pkg::YEAR_W];
    assign out_month = odate_reg[sudt_pkg::DAY_W +: sudt_pkg::MONTH_W];
    assign out_day   = odate_reg[sudt_pkg::DAY_W-1:0];

`ifndef NO_ASSERTIONS
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && last_reg) |-> (state_reg == S_IDLE))
        else $error("final result while sequencer still busy");

    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= sudt_pkg::CAP_CNT)
        else $error("entry count above capacity");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start the sequencer");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (status_reg != sudt_pkg::ST_LISTED)) |-> last_reg)
        else $error("insert or empty result without last");

    a_cnt_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |->
            (valid_reg && (status_reg == sudt_pkg::ST_INSERTED)))
        else $error("entry count changed without an insert");
`endif

endmodule

/* verif/sorted_unique_date_table_tb.sv */
// Testbench for sorted_unique_date_table: directed and random insert/list words, self-checking.
// A shadow table predicts every result word; needs sudt_pkg and the block's RTL only.
`timescale 1ns / 1ps

module sorted_unique_date_table_tb;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LIST   = 1'b1;

    typedef struct {
        sudt_pkg::stat_t status;
        sudt_pkg::date_t date;
        logic            last;
    } outcome_t;

    class sorted_date_shadow;
        sudt_pkg::date_t dates [sudt_pkg::CAPACITY];
        int              stored;
        outcome_t        due_words [$];
        int              mismatches;

        function new();
            stored     = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        function void push_outcome(sudt_pkg::stat_t s, sudt_pkg::date_t d, logic l);
            outcome_t o;
            o.status = s;
            o.date   = d;
            o.last   = l;
            due_words.push_back(o);
        endfunction

        function void take_word(logic f, logic [sudt_pkg::YEAR_W-1:0] y,
                                logic [sudt_pkg::MONTH_W-1:0] m,
                                logic [sudt_pkg::DAY_W-1:0] d);
            sudt_pkg::date_t key;
            bit              seen;
            int              i;
            key  = {y, m, d};
            seen = 0;
            if (f == FUNC_INSERT)
            begin
                for (i = 0; i < stored; i++)
                    if (dates[i] == key)
                        seen = 1;
                if (seen)
                    push_outcome(sudt_pkg::ST_DUP, '0, 1'b1);
                else if (stored >= sudt_pkg::CAPACITY)
                    push_outcome(sudt_pkg::ST_FULL, '0, 1'b1);
                else
                begin
                    i = stored;
                    while (i > 0 && key < dates[i-1])
                    begin
                        dates[i] = dates[i-1];
                        i--;
                    end
                    dates[i] = key;
                    stored++;
                    push_outcome(sudt_pkg::ST_INSERTED, '0, 1'b1);
                end
            end
            else if (stored == 0)
                push_outcome(sudt_pkg::ST_EMPTY, '0, 1'b1);
            else
                for (i = 0; i < stored; i++)
                    push_outcome(sudt_pkg::ST_LISTED, dates[i], (i == stored - 1));
        endfunction

        function void report(string field, int exp_v, int act_v);
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, exp_v, act_v);
            mismatches++;
        endfunction

        function void check_word(sudt_pkg::stat_t s, logic [sudt_pkg::YEAR_W-1:0] y,
                                 logic [sudt_pkg::MONTH_W-1:0] m,
                                 logic [sudt_pkg::DAY_W-1:0] d, logic l);
            outcome_t e;
            if (due_words.size() == 0)
            begin
                $display("%0t ns: unexpected result word, code %0d", $time, s);
                mismatches++;
                return;
            end
            e = due_words.pop_front();
            if (s !== e.status)
                report("code", e.status, s);
            if (y !== e.date[sudt_pkg::DATE_W-1 -: sudt_pkg::YEAR_W])
                report("out_year", e.date[sudt_pkg::DATE_W-1 -: sudt_pkg::YEAR_W], y);
            if (m !== e.date[sudt_pkg::MONTH_W+sudt_pkg::DAY_W-1 -: sudt_pkg::MONTH_W])
                report("out_month",
                       e.date[sudt_pkg::MONTH_W+sudt_pkg::DAY_W-1 -: sudt_pkg::MONTH_W], m);
            if (d !== e.date[sudt_pkg::DAY_W-1:0])
                report("out_day", e.date[sudt_pkg::DAY_W-1:0], d);
            if (l !== e.last)
                report("last", e.last, l);
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic                          func;
    logic [sudt_pkg::YEAR_W-1:0]   year;
    logic [sudt_pkg::MONTH_W-1:0]  month;
    logic [sudt_pkg::DAY_W-1:0]    day;
    logic                          valid;
    logic [sudt_pkg::STAT_W-1:0]   status;
    logic [sudt_pkg::YEAR_W-1:0]   out_year;
    logic [sudt_pkg::MONTH_W-1:0]  out_month;
    logic [sudt_pkg::DAY_W-1:0]    out_day;
    logic                          last;

    sorted_date_shadow   shadow;
    bit                  quiet;

    sorted_unique_date_table uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .year      (year),
        .month     (month),
        .day       (day),
        .valid     (valid),
        .status    (status),
        .out_year  (out_year),
        .out_month (out_month),
        .out_day   (out_day),
        .last      (last)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && valid)
            shadow.check_word(status, out_year, out_month, out_day, last);
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic send_word(input logic f, input logic [sudt_pkg::YEAR_W-1:0] y,
                             input logic [sudt_pkg::MONTH_W-1:0] m,
                             input logic [sudt_pkg::DAY_W-1:0] d);
        start <= 1'b1;
        func  <= f;
        year  <= y;
        month <= m;
        day   <= d;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        shadow.take_word(f, y, m, d);
    endtask

    task automatic feed(input logic f, input logic [sudt_pkg::YEAR_W-1:0] y,
                        input logic [sudt_pkg::MONTH_W-1:0] m,
                        input logic [sudt_pkg::DAY_W-1:0] d);
        if (!quiet && $urandom_range(0, 99) < 9)
        begin
            start <= 1'b0;
            if ($urandom_range(0, 1) == 0)
                repeat ($urandom_range(1, 6)) @(posedge clk);
            else
                repeat ($urandom_range(7, 80)) @(posedge clk);
        end
        send_word(f, y, m, d);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (shadow.pending() != 0)
            @(posedge clk);
    endtask

    task automatic pick_date(output logic [sudt_pkg::YEAR_W-1:0] y,
                             output logic [sudt_pkg::MONTH_W-1:0] m,
                             output logic [sudt_pkg::DAY_W-1:0] d);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            y = sudt_pkg::YEAR_W'(2000 + $urandom_range(0, 3));
            m = sudt_pkg::MONTH_W'($urandom_range(1, 12));
            d = sudt_pkg::DAY_W'($urandom_range(1, 31));
        end
        else if (r < 80)
        begin
            y = sudt_pkg::YEAR_W'(2024);
            m = sudt_pkg::MONTH_W'(6);
            d = sudt_pkg::DAY_W'($urandom_range(0, 31));
        end
        else
        begin
            y = sudt_pkg::YEAR_W'($urandom_range(0, 16383));
            m = sudt_pkg::MONTH_W'($urandom_range(0, 15));
            d = sudt_pkg::DAY_W'($urandom_range(0, 31));
        end
    endtask

    task automatic feed_new();
        logic [sudt_pkg::YEAR_W-1:0]  y;
        logic [sudt_pkg::MONTH_W-1:0] m;
        logic [sudt_pkg::DAY_W-1:0]   d;
        pick_date(y, m, d);
        feed(FUNC_INSERT, y, m, d);
    endtask

    task automatic feed_repeat();
        sudt_pkg::date_t k;
        k = shadow.dates[$urandom_range(0, shadow.stored - 1)];
        feed(FUNC_INSERT, k[sudt_pkg::DATE_W-1 -: sudt_pkg::YEAR_W],
             k[sudt_pkg::MONTH_W+sudt_pkg::DAY_W-1 -: sudt_pkg::MONTH_W],
             k[sudt_pkg::DAY_W-1:0]);
    endtask

    task automatic feed_list();
        feed(FUNC_LIST, sudt_pkg::YEAR_W'($urandom_range(0, 16383)),
             sudt_pkg::MONTH_W'($urandom_range(0, 15)),
             sudt_pkg::DAY_W'($urandom_range(0, 31)));
    endtask

    initial
    begin
        int n;
        int r;
        shadow = new();
        quiet  = 0;
        rst_n  = 1'b0;
        start  = 1'b0;
        func   = FUNC_INSERT;
        year   = '0;
        month  = '0;
        day    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        feed(FUNC_LIST, 14'd16383, 4'd15, 5'd31);
        feed(FUNC_INSERT, 14'd2024, 4'd6, 5'd15);
        feed(FUNC_INSERT, 14'd2024, 4'd6, 5'd15);
        feed(FUNC_INSERT, 14'd0, 4'd0, 5'd0);
        feed(FUNC_INSERT, 14'd16383, 4'd15, 5'd31);
        feed(FUNC_INSERT, 14'd2024, 4'd6, 5'd14);
        feed(FUNC_INSERT, 14'd2024, 4'd5, 5'd31);
        feed(FUNC_INSERT, 14'd2023, 4'd12, 5'd31);
        feed(FUNC_INSERT, 14'd2024, 4'd13, 5'd0);
        feed(FUNC_INSERT, 14'd9999, 4'd12, 5'd31);
        feed(FUNC_INSERT, 14'd0, 4'd1, 5'd1);
        feed(FUNC_INSERT, 14'd0, 4'd0, 5'd0);
        feed(FUNC_LIST, 14'd0, 4'd0, 5'd0);
        feed(FUNC_INSERT, 14'd5461, 4'd10, 5'd21);
        feed(FUNC_INSERT, 14'd10922, 4'd5, 5'd10);
        feed(FUNC_LIST, 14'd5461, 4'd10, 5'd21);
        drain();

        for (n = 0; n < 150; n++)
        begin
            quiet = (n >= 50 && n < 100);
            if (n == 75)
                drain();
            r = $urandom_range(0, 99);
            if (r < 18)
                feed_list();
            else if (r < 40 && shadow.stored > 0)
                feed_repeat();
            else
                feed_new();
        end

        quiet = 0;
        while (shadow.stored < sudt_pkg::CAPACITY)
            feed_new();
        feed_repeat();
        feed(FUNC_INSERT, 14'd16383, 4'd15, 5'd31);
        feed(FUNC_INSERT, 14'd7777, 4'd3, 5'd3);
        feed_new();
        feed_list();
        feed_repeat();
        feed_list();

        drain();
        repeat (80) @(posedge clk);
        if (shadow.mismatches == 0 && shadow.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
